// ----- hdl/vsa_pkg.sv -----
// Package for the voice slot allocator: command codes, slot entry layout,
// latched command word and scan-unit result struct.
// No dependencies.
package vsa_pkg;

  localparam logic [2:0] CMD_CLAIM         = 3'd0;
  localparam logic [2:0] CMD_STEAL         = 3'd1;
  localparam logic [2:0] CMD_LOOKUP_HANDLE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP_GAME   = 3'd3;
  localparam logic [2:0] CMD_RELEASE_ALL   = 3'd4;
  localparam logic [2:0] CMD_RELEASE_GROUP = 3'd5;
  localparam logic [2:0] CMD_SET_SLOT      = 3'd6;
  localparam logic [2:0] CMD_RELEASE_SLOT  = 3'd7;

  localparam logic [5:0] LIMIT_RESET     = 6'd32;
  localparam int         CFG_ADDR_W      = 3;
  localparam logic       REG_VOICE_LIMIT = 1'b0;

  typedef struct packed {
    logic        playing;
    logic [15:0] generation;
    logic [15:0] volume;
    logic        looping;
    logic [2:0]  group;
    logic        owner_valid;
    logic [31:0] owner;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  slot;
    logic        handle_valid;
    logic [15:0] handle_index;
    logic [15:0] handle_generation;
    logic        game_handle_valid;
    logic [31:0] game_handle;
    logic [15:0] volume;
    logic        looping;
    logic [2:0]  group;
  } cmd_t;

  typedef struct packed {
    logic take;  // entry becomes the current candidate
    logic wr;    // entry is written back
    logic rel;   // a playing slot goes idle
  } scan_res_t;

endpackage

// ----- hdl/vsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vsa_scan_unit.sv -----
// Per-entry evaluator shared by every scan step: decides candidate take,
// write-back and release for one slot entry. Depends on vsa_pkg.
module vsa_scan_unit (
  input  vsa_pkg::cmd_t        cmd_i,
  input  logic [5:0]           limit_i,
  input  logic [15:0]          idx_i,
  input  vsa_pkg::slot_entry_t entry_i,
  input  logic                 have_i,
  input  logic [15:0]          best_vol_i,
  output vsa_pkg::scan_res_t   res_o,
  output vsa_pkg::slot_entry_t wdata_o
);
  import vsa_pkg::*;

  logic below;
  logic at_slot;
  slot_entry_t cleared;
  slot_entry_t written;

  assign below   = idx_i < {10'b0, limit_i};
  assign at_slot = idx_i == {11'b0, cmd_i.slot};

  // release keeps the generation only
  assign cleared = '{playing: 1'b0, generation: entry_i.generation, volume: 16'd0,
                     looping: 1'b0, group: 3'd0, owner_valid: 1'b0, owner: 32'd0};
  assign written = '{playing: entry_i.playing, generation: entry_i.generation,
                     volume: cmd_i.volume, looping: cmd_i.looping, group: cmd_i.group,
                     owner_valid: cmd_i.game_handle_valid, owner: cmd_i.game_handle};

  always_comb begin
    res_o   = '0;
    wdata_o = cleared;
    case (cmd_i.command)
      CMD_CLAIM: begin
        res_o.take = !entry_i.playing && below && !have_i;
      end
      CMD_STEAL: begin
        res_o.take = entry_i.playing && !entry_i.looping && below &&
                     (!have_i || (entry_i.volume < best_vol_i));
      end
      CMD_LOOKUP_HANDLE: begin
        res_o.take = cmd_i.handle_valid && (idx_i == cmd_i.handle_index) &&
                     (entry_i.generation == cmd_i.handle_generation);
      end
      CMD_LOOKUP_GAME: begin
        res_o.take = cmd_i.game_handle_valid && entry_i.playing && entry_i.owner_valid &&
                     (entry_i.owner == cmd_i.game_handle) && !have_i;
      end
      CMD_RELEASE_ALL: begin
        res_o.wr  = entry_i.playing;
        res_o.rel = entry_i.playing;
      end
      CMD_RELEASE_GROUP: begin
        res_o.wr  = entry_i.playing && (entry_i.group == cmd_i.group);
        res_o.rel = res_o.wr;
      end
      CMD_SET_SLOT: begin
        res_o.wr = at_slot;
        wdata_o  = written;
      end
      CMD_RELEASE_SLOT: begin
        res_o.wr  = at_slot && entry_i.playing;
        res_o.rel = res_o.wr;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ----- hdl/voice_slot_allocator_with_stealing.sv -----
// Voice slot allocator with quietest-voice stealing.
// Input channel: in_valid_i / in_stall_o carry one command word with its
// fields; output channel: out_valid_o / out_stall_i carry one result word
// (ok, slot, generation, active count) per command.
// Every command sweeps all MAX_SLOTS entries of the slot RAM, one entry per
// cycle through the shared scan unit, then passes through a drain state and an
// arm state that re-arms the chosen slot (claim or steal) and loads the result.
// The single RAM read port is why the entries are scanned one at a time.
// in_stall_o is high from accept until the result is loaded into the output
// register; the next command may be taken while that result waits.
// A new command is taken only after the previous result has been loaded.
// If the receiver stalls, the result holds, and a following command waits in
// the arm state until the output register frees.
// Reset idles all slots and zeroes generations and attributes at once through
// per-slot written bits; no clearing pass. voice_limit resets to 32.
// APB port: voice_limit at address 0, pready always high.
// Depends on vsa_pkg, vsa_ram, vsa_scan_unit.
module voice_slot_allocator_with_stealing #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vsa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     command_i,
  input  logic [4:0]                     slot_i,
  input  logic                           handle_valid_i,
  input  logic [15:0]                    handle_index_i,
  input  logic [15:0]                    handle_generation_i,
  input  logic                           game_handle_valid_i,
  input  logic [31:0]                    game_handle_i,
  input  logic [15:0]                    volume_i,
  input  logic                           looping_i,
  input  logic [2:0]                     group_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ok_o,
  output logic [4:0]                     result_slot_o,
  output logic [15:0]                    result_generation_o,
  output logic [5:0]                     active_count_o
);
  import vsa_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ARM   = 2'd3;

  logic [1:0]           state_q, state_d;
  cmd_t                 cmd_q;
  logic [IDX_W-1:0]     scan_idx_q;
  logic                 eval_v_q;
  logic [IDX_W-1:0]     eval_idx_q;
  logic                 rd_written_q;
  logic [MAX_SLOTS-1:0] written_q;
  logic                 have_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [15:0]          best_gen_q;
  logic [15:0]          best_vol_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [5:0]           limit_q;
  logic                 out_valid_q;
  logic                 ok_q;
  logic [4:0]           slot_q;
  logic [15:0]          gen_q;
  logic [5:0]           count_q;

  logic                 in_accept;
  logic                 cfg_write;
  logic                 out_free;
  logic                 finish;
  logic                 arm_go;
  logic                 claim_inc;
  logic [15:0]          gen_inc;
  logic [ENTRY_W-1:0]   ram_rdata;
  slot_entry_t          entry;
  slot_entry_t          scan_wdata;
  slot_entry_t          arm_entry;
  scan_res_t            res;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  slot_entry_t          ram_wdata;
  logic [15:0]          eval_idx_ext;
  logic [15:0]          best_idx_ext;
  logic [IDX_W+4:0]     idx_wide;
  logic [CNT_W+5:0]     cnt_wide;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VOICE_LIMIT) ? {26'b0, limit_q} : 32'd0;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign finish    = (state_q == S_ARM) && out_free;
  assign arm_go    = finish && have_q &&
                     ((cmd_q.command == CMD_CLAIM) || (cmd_q.command == CMD_STEAL));
  assign claim_inc = finish && have_q && (cmd_q.command == CMD_CLAIM);
  assign gen_inc   = best_gen_q + 16'd1;

  assign eval_idx_ext = {{(16 - IDX_W){1'b0}}, eval_idx_q};
  assign best_idx_ext = {{(16 - IDX_W){1'b0}}, best_idx_q};
  assign idx_wide     = {5'b0, best_idx_q};
  assign cnt_wide     = {6'b0, cnt_d};

  // unwritten entries read as the reset value
  assign entry = rd_written_q ? slot_entry_t'(ram_rdata) : '0;

  assign arm_entry = '{playing: 1'b1, generation: gen_inc, volume: 16'd0, looping: 1'b0,
                       group: 3'd0, owner_valid: 1'b0, owner: 32'd0};

  vsa_scan_unit u_scan (
    .cmd_i      (cmd_q),
    .limit_i    (limit_q),
    .idx_i      (eval_idx_ext),
    .entry_i    (entry),
    .have_i     (have_q),
    .best_vol_i (best_vol_q),
    .res_o      (res),
    .wdata_o    (scan_wdata)
  );

  assign ram_we    = (eval_v_q && res.wr) || arm_go;
  assign ram_waddr = arm_go ? best_idx_q : eval_idx_q;
  assign ram_wdata = arm_go ? arm_entry : scan_wdata;

  vsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_SCAN),
    .raddr_i (scan_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (eval_v_q && res.rel) begin
      cnt_d = cnt_q - CNT_W'(1);
    end else if (claim_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx_q == LAST_IDX) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_ARM;
      end
      S_ARM: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_idx_q   <= '0;
      eval_v_q     <= 1'b0;
      rd_written_q <= 1'b0;
      written_q    <= '0;
      have_q       <= 1'b0;
      cnt_q        <= '0;
      limit_q      <= LIMIT_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      eval_v_q <= state_q == S_SCAN;
      cnt_q    <= cnt_d;
      if (cfg_write && (paddr[2] == REG_VOICE_LIMIT)) begin
        limit_q <= pwdata[5:0];
      end
      if (in_accept) begin
        scan_idx_q <= '0;
        have_q     <= 1'b0;
      end else if (state_q == S_SCAN) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (state_q == S_SCAN) begin
        rd_written_q <= written_q[scan_idx_q];
      end
      if (eval_v_q && res.take) begin
        have_q <= 1'b1;
      end
      if (ram_we) begin
        written_q[ram_waddr] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= '{command: command_i, slot: slot_i, handle_valid: handle_valid_i,
                 handle_index: handle_index_i, handle_generation: handle_generation_i,
                 game_handle_valid: game_handle_valid_i, game_handle: game_handle_i,
                 volume: volume_i, looping: looping_i, group: group_i};
    end
    if (state_q == S_SCAN) begin
      eval_idx_q <= scan_idx_q;
    end
    if (eval_v_q && res.take) begin
      best_idx_q <= eval_idx_q;
      best_gen_q <= entry.generation;
      best_vol_q <= entry.volume;
    end
    if (finish) begin
      ok_q    <= have_q;
      slot_q  <= have_q ? idx_wide[4:0] : 5'd0;
      gen_q   <= !have_q ? 16'd0 : (arm_go ? gen_inc : best_gen_q);
      count_q <= cnt_wide[5:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign ok_o                = ok_q;
  assign result_slot_o       = slot_q;
  assign result_generation_o = gen_q;
  assign active_count_o      = count_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SLOTS))
    else $error("active count above slot count");

  a_arm_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arm_go |-> (best_idx_ext < {10'b0, limit_q}))
    else $error("armed slot outside voice limit");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SCAN))
    else $error("accepted word did not start a scan");

  a_drain_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (state_q == S_ARM))
    else $error("drain not followed by arm");
`endif

endmodule
